// ===== rtl/assert_macros.svh =====
// assertion helpers used by the scheduler top
// expects clk and arst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define HPJS_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// consequence checked in the cycle after the trigger
`define HPJS_CHECK_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== rtl/hpjs_pkg.sv =====
`default_nettype none

package hpjs_pkg;

	localparam int CAPACITY = 64;
	localparam int POS_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);

	typedef logic [POS_W-1:0] pos_t;
	typedef logic [CNT_W-1:0] cnt_t;
	// child index, wide enough for 2*pos+2
	typedef logic [POS_W+1:0] ch_t;

	localparam logic KIND_ARRIVE = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_DROPPED = 2'd1,
		ST_RAN = 2'd2,
		ST_IDLE = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0] name;
		logic [15:0] prio;
		logic [15:0] burst;
	} entry_t;

	typedef struct packed {
		status_t status;
		logic [7:0] ran_name;
		logic [15:0] remaining;
		logic finished;
		logic [6:0] occupancy;
	} rsp_t;

	// compare step inputs and decision
	typedef struct packed {
		logic down;
		logic b_valid;
		logic [15:0] cur_prio;
	} cmp_ctl_t;

	typedef struct packed {
		logic move;
		logic pick_b;
	} cmp_res_t;

endpackage

`default_nettype wire

// ===== rtl/hpjs_if.sv =====
`default_nettype none

interface hpjs_req_if import hpjs_pkg::*; ();
	logic valid;
	logic ready;
	logic kind;
	logic [7:0] job_id;
	logic [15:0] job_priority;
	logic [15:0] job_burst;

	modport source (output valid, kind, job_id, job_priority, job_burst, input ready);
	modport sink (input valid, kind, job_id, job_priority, job_burst, output ready);
endinterface

interface hpjs_rsp_if import hpjs_pkg::*; ();
	logic valid;
	logic ready;
	status_t status;
	logic [7:0] ran_name;
	logic [15:0] remaining;
	logic finished;
	logic [6:0] occupancy;

	modport source (output valid, status, ran_name, remaining, finished, occupancy,
		input ready);
	modport sink (input valid, status, ran_name, remaining, finished, occupancy,
		output ready);
endinterface

`default_nettype wire

// ===== rtl/heap_priority_job_scheduler_top.sv =====
`default_nettype none
`include "assert_macros.svh"

// Priority job scheduler on a binary min-heap of up to CAPACITY (64) jobs, each
// {name, priority, burst}, held in one on-chip memory with one write port and two
// registered read ports. A request of kind arrive inserts a job at the slot past the
// last one and sifts it toward the root (it passes a parent only when that parent's
// priority is strictly greater); a full heap drops the job with status dropped. A
// request of kind tick runs the root job for one unit, saturating its burst at zero;
// at zero the job is removed, the last job takes the root and sifts down, preferring
// the left child on ties. A tick on an empty heap reports idle. Every request yields
// exactly one response carrying the occupancy after it. Requests are handled one at a
// time: an arrive reads the parent and compares once per level climbed, a tick reads
// the root and updates it, and a tick that removes a job then fetches the last job and
// reads both children and compares once per level descended. Each level has a read
// state and a compare state, as the single shared compare step waits on the registered
// memory read before each decision. A finished response sits in an output register, so
// the next request is taken and worked on while the previous response waits; a request
// that finishes while the register is still full waits until the response ahead of it
// is taken. The heap memory needs no clearing after reset.
module heap_priority_job_scheduler_top import hpjs_pkg::*; (
	input var logic clk,
	input var logic arst_n,
	hpjs_req_if.sink req,
	hpjs_rsp_if.source rsp
);

	// sequencer states
	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_UP_RD = 9'b000000010,
		S_UP_CMP = 9'b000000100,
		S_T_RD = 9'b000001000,
		S_T_EXE = 9'b000010000,
		S_D_LAST = 9'b000100000,
		S_D_RD = 9'b001000000,
		S_D_CMP = 9'b010000000,
		S_FIN = 9'b100000000
	} state_t;

	localparam cnt_t CNT_CAP = cnt_t'(CAPACITY);

	state_t state_q;
	cnt_t count_q;
	pos_t pos_q;
	entry_t cur_q;
	rsp_t res_q;
	rsp_t out_q;
	logic out_valid_q;

	// heap memory
	entry_t heap_mem [CAPACITY];
	entry_t rd_a_q;
	entry_t rd_b_q;
	logic mem_we;
	pos_t mem_waddr;
	entry_t mem_wdata;
	logic mem_re;
	pos_t rd_addr_a;
	pos_t rd_addr_b;

	// index arithmetic around the hole
	pos_t par_idx;
	ch_t l_idx;
	ch_t r_idx;
	logic l_out;
	cnt_t count_dec;

	// tick on the root
	logic [15:0] burst_dec;
	entry_t root_upd;

	cmp_ctl_t cmp_ctl;
	cmp_res_t cmp_res;
	entry_t child;
	pos_t child_pos;

	logic in_take;
	logic out_free;

	assign req.ready = (state_q == S_IDLE);
	assign in_take = req.valid && req.ready;

	assign rsp.valid = out_valid_q;
	assign rsp.status = out_q.status;
	assign rsp.ran_name = out_q.ran_name;
	assign rsp.remaining = out_q.remaining;
	assign rsp.finished = out_q.finished;
	assign rsp.occupancy = out_q.occupancy;
	assign out_free = !out_valid_q || rsp.ready;

	assign par_idx = pos_t'((pos_q - 1'b1) >> 1);
	assign l_idx = (ch_t'(pos_q) << 1) + 1'b1;
	assign r_idx = l_idx + 1'b1;
	assign l_out = (l_idx >= ch_t'(count_q));
	assign count_dec = count_q - 1'b1;

	assign burst_dec = (rd_a_q.burst != 16'd0) ? (rd_a_q.burst - 1'b1) : 16'd0;
	always_comb begin
		root_upd = rd_a_q;
		root_upd.burst = burst_dec;
	end

	// shared compare step, used by both sift directions
	assign cmp_ctl.down = (state_q == S_D_CMP);
	assign cmp_ctl.b_valid = (r_idx < ch_t'(count_q));
	assign cmp_ctl.cur_prio = cur_q.prio;

	hpjs_sift_cmp u_cmp (
		.ctl(cmp_ctl),
		.a(rd_a_q),
		.b(rd_b_q),
		.res(cmp_res)
	);

	assign child = cmp_res.pick_b ? rd_b_q : rd_a_q;
	assign child_pos = cmp_res.pick_b ? r_idx[POS_W-1:0] : l_idx[POS_W-1:0];

	// memory port control
	always_comb begin
		mem_we = 1'b0;
		mem_waddr = pos_q;
		mem_wdata = cur_q;
		mem_re = 1'b0;
		rd_addr_a = '0;
		rd_addr_b = '0;
		case (state_q)
			S_UP_RD: begin
				if (pos_q == '0) begin
					mem_we = 1'b1;
				end else begin
					mem_re = 1'b1;
					rd_addr_a = par_idx;
				end
			end
			S_UP_CMP: begin
				// parent moves down into the hole, or the new job settles
				mem_we = 1'b1;
				if (cmp_res.move) begin
					mem_wdata = rd_a_q;
				end
			end
			S_T_RD: begin
				mem_re = 1'b1;
			end
			S_T_EXE: begin
				if (burst_dec != 16'd0) begin
					mem_we = 1'b1;
					mem_waddr = '0;
					mem_wdata = root_upd;
				end else begin
					// fetch the last job to refill the root
					mem_re = 1'b1;
					rd_addr_a = count_dec[POS_W-1:0];
				end
			end
			S_D_RD: begin
				if (l_out) begin
					mem_we = 1'b1;
				end else begin
					mem_re = 1'b1;
					rd_addr_a = l_idx[POS_W-1:0];
					rd_addr_b = r_idx[POS_W-1:0];
				end
			end
			S_D_CMP: begin
				mem_we = 1'b1;
				if (cmp_res.move) begin
					mem_wdata = child;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			heap_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_a_q <= heap_mem[rd_addr_a];
			rd_b_q <= heap_mem[rd_addr_b];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// a new response refills the register, else a taken one empties it
			if ((state_q == S_FIN) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.valid && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_take) begin
						res_q.ran_name <= '0;
						res_q.remaining <= '0;
						res_q.finished <= 1'b0;
						if (req.kind == KIND_ARRIVE) begin
							if (count_q >= CNT_CAP) begin
								res_q.status <= ST_DROPPED;
								state_q <= S_FIN;
							end else begin
								cur_q.name <= req.job_id;
								cur_q.prio <= req.job_priority;
								cur_q.burst <= req.job_burst;
								pos_q <= count_q[POS_W-1:0];
								count_q <= count_q + 1'b1;
								state_q <= S_UP_RD;
							end
						end else if (count_q == '0) begin
							res_q.status <= ST_IDLE;
							state_q <= S_FIN;
						end else begin
							state_q <= S_T_RD;
						end
					end
				end
				S_UP_RD: begin
					if (pos_q == '0) begin
						res_q.status <= ST_INSERTED;
						state_q <= S_FIN;
					end else begin
						state_q <= S_UP_CMP;
					end
				end
				S_UP_CMP: begin
					if (cmp_res.move) begin
						pos_q <= par_idx;
						state_q <= S_UP_RD;
					end else begin
						res_q.status <= ST_INSERTED;
						state_q <= S_FIN;
					end
				end
				S_T_RD: begin
					state_q <= S_T_EXE;
				end
				S_T_EXE: begin
					res_q.status <= ST_RAN;
					res_q.ran_name <= rd_a_q.name;
					res_q.remaining <= burst_dec;
					res_q.finished <= (burst_dec == 16'd0);
					if (burst_dec != 16'd0) begin
						state_q <= S_FIN;
					end else begin
						count_q <= count_dec;
						// last job gone, nothing to refill
						state_q <= (count_dec == '0) ? S_FIN : S_D_LAST;
					end
				end
				S_D_LAST: begin
					cur_q <= rd_a_q;
					pos_q <= '0;
					state_q <= S_D_RD;
				end
				S_D_RD: begin
					state_q <= l_out ? S_FIN : S_D_CMP;
				end
				S_D_CMP: begin
					if (cmp_res.move) begin
						pos_q <= child_pos;
						state_q <= S_D_RD;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						out_q.status <= res_q.status;
						out_q.ran_name <= res_q.ran_name;
						out_q.remaining <= res_q.remaining;
						out_q.finished <= res_q.finished;
						out_q.occupancy <= 7'(count_q);
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`HPJS_CHECK(a_count_bound, count_q <= CNT_CAP, "job count above capacity")
	`HPJS_CHECK(a_wr_in_heap, !mem_we || (ch_t'(mem_waddr) < ch_t'(count_q)),
		"heap write outside held jobs")
	`HPJS_CHECK_NEXT(a_arrive_count,
		in_take && (req.kind == KIND_ARRIVE) && (count_q < CNT_CAP),
		count_q == $past(count_q) + 1'b1, "arrive did not grow the heap")
	`HPJS_CHECK(a_up_not_root, (state_q != S_UP_CMP) || (pos_q != '0),
		"sift up compared at the root")

endmodule

`default_nettype wire

// ===== rtl/hpjs_sift_cmp.sv =====
`default_nettype none

// one sift step decision: parent check going up, child pick and check going down
module hpjs_sift_cmp import hpjs_pkg::*; (
	input var cmp_ctl_t ctl,
	input var entry_t a,
	input var entry_t b,
	output cmp_res_t res
);

	logic b_wins;
	logic [15:0] child_prio;

	// left child wins ties
	assign b_wins = ctl.b_valid && (b.prio < a.prio);
	assign child_prio = b_wins ? b.prio : a.prio;

	assign res.move = ctl.down ? (child_prio < ctl.cur_prio) : (a.prio > ctl.cur_prio);
	assign res.pick_b = ctl.down && b_wins;

endmodule

`default_nettype wire
